### hw/rtl/msb_first_bit_field_reader_core_defines.svh
// Assertion shorthands for the bit field reader.
`ifndef MSB_FIRST_BIT_FIELD_READER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_FIELD_READER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MFBR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define MFBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mfbr_pkg.sv
`default_nettype none

package mfbr_pkg;

    localparam int DEFAULT_BUFFER_DEPTH   = 4096;
    localparam int DEFAULT_MAX_FIELD_BITS = 32;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 13;
    localparam int ADDR_W   = 12;
    localparam int CNT_W    = 6;
    localparam int TOP_W    = 5;
    localparam int FIELD_W  = 32;
    localparam int BYTES_W  = 13;
    localparam int OPCODE_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_READ_U  = 2'd1,
        OP_READ_S  = 2'd2,
        OP_REWIND  = 2'd3
    } op_t;

endpackage

`default_nettype wire

### hw/rtl/mfbr_byte_ram.sv
`default_nettype none

module mfbr_byte_ram
    import mfbr_pkg::*;
#(
    parameter int DEPTH = DEFAULT_BUFFER_DEPTH
)
(
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   addr,
    input  wire logic [BYTE_W-1:0]          wdata,
    output logic      [BYTE_W-1:0]          rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/msb_first_bit_field_reader_core.sv
`default_nettype none
// Steps: a load, a rewind or a read that starts past the valid length goes from accept to the
// done step; a read takes one shift step per byte it spans, then a zero fill step when it runs
// off the valid length, then the done step, which registers the result. The widest read is a
// 32-bit field over five bytes, one byte a cycle from a single-port byte RAM. s_tready is high
// only when idle; a stalled result holds the next word in its final step. rst_n is asynchronous:
// clears the state, the cursor, buffer_length and the result valid.

`include "msb_first_bit_field_reader_core_defines.svh"

module msb_first_bit_field_reader_core
    import mfbr_pkg::*;
#(
    parameter int BUFFER_DEPTH   = DEFAULT_BUFFER_DEPTH,
    parameter int MAX_FIELD_BITS = DEFAULT_MAX_FIELD_BITS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [LEN_W-1:0]  cfg_wr_data,   // buffer_length
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,       // byte_address[11:0], byte_value[19:12],
                                                  // bit_count[25:20], zero above
    input  wire logic [1:0]        s_tuser,       // opcode[1:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [47:0]       m_tdata        // field_value[31:0], bytes_consumed[44:32],
                                                  // zero above
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = AW + 4;
    localparam int LW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
    localparam int SW = (CW + 1 > 16) ? CW + 1 : 16;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg;
    logic [CW-1:0]      cursor_reg, cursor_next;
    logic [FIELD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               sgn_reg, sgn_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] out_field_reg, out_field_next;
    logic [BYTES_W-1:0] out_bytes_reg, out_bytes_next;

    op_t                in_op;
    logic [ADDR_W-1:0]  in_addr;
    logic [BYTE_W-1:0]  in_val;
    logic [CNT_W-1:0]   in_cnt;
    logic               s_accept;

    logic [LW-1:0]      valid_len;
    logic [LW-1:0]      addr_ext;
    logic [AW:0]        cur_pos;
    logic               cur_in;
    logic [CNT_W-1:0]   max_u, max_s, sat_u, sat_s;

    logic [2:0]         off;
    logic [3:0]         room;
    logic [3:0]         take;
    logic [BYTE_W-1:0]  aligned;
    logic [BYTE_W-1:0]  bits;
    logic [FIELD_W-1:0] acc_merge;
    logic [CW-1:0]      cursor_adv;
    logic [CNT_W-1:0]   rem_left;
    logic [AW:0]        nxt_pos;
    logic               nxt_in;

    logic [FIELD_W-1:0] sign_mask;
    logic [SW-1:0]      round_sum;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [BYTE_W-1:0]  ram_rdata;

    assign in_op    = op_t'(s_tuser);
    assign in_addr  = s_tdata[11:0];
    assign in_val   = s_tdata[19:12];
    assign in_cnt   = s_tdata[25:20];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign valid_len = (LW'(len_reg) > LW'(BUFFER_DEPTH)) ? LW'(BUFFER_DEPTH) : LW'(len_reg);
    assign addr_ext  = LW'(in_addr);
    assign cur_pos   = cursor_reg[CW-1:3];
    assign cur_in    = LW'(cur_pos) < valid_len;

    assign max_u = CNT_W'(MAX_FIELD_BITS);
    assign max_s = CNT_W'(MAX_FIELD_BITS - 2);
    assign sat_u = (in_cnt > max_u) ? max_u : in_cnt;
    assign sat_s = (in_cnt > max_s) ? max_s : in_cnt;

    // shift unit: take up to the rest of the current byte, MSB first
    assign off        = cursor_reg[2:0];
    assign room       = 4'd8 - {1'b0, off};
    assign take       = (rem_reg < CNT_W'(room)) ? rem_reg[3:0] : room;
    assign aligned    = ram_rdata << off;
    assign bits       = aligned >> (4'd8 - take);
    assign acc_merge  = (acc_reg << take) | FIELD_W'(bits);
    assign cursor_adv = cursor_reg + CW'(take);
    assign rem_left   = rem_reg - CNT_W'(take);
    assign nxt_pos    = cursor_adv[CW-1:3];
    assign nxt_in     = LW'(nxt_pos) < valid_len;

    assign sign_mask = ~((FIELD_W'(1) << top_reg) - FIELD_W'(1));
    assign round_sum = SW'(cursor_reg) + SW'(7);

    // prefetch the next byte while the current one is being shifted in
    always_comb
    begin
        ram_we = 1'b0;
        if (state_reg == ST_SHIFT)
        begin
            ram_addr = nxt_pos[AW-1:0];
        end
        else if (in_op == OP_LOAD)
        begin
            ram_addr = addr_ext[AW-1:0];
            ram_we   = s_accept && (addr_ext < LW'(BUFFER_DEPTH));
        end
        else
        begin
            ram_addr = cur_pos[AW-1:0];
        end
    end

    mfbr_byte_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_byte_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_val),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        sgn_next       = sgn_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        out_field_next = out_field_reg;
        out_bytes_next = out_bytes_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    acc_next   = '0;
                    sgn_next   = 1'b0;
                    state_next = ST_DONE;
                    case (in_op)
                        OP_LOAD:
                        begin
                            rem_next = '0;
                        end
                        OP_READ_U:
                        begin
                            rem_next = sat_u;
                            if ((sat_u != '0) && cur_in)
                            begin
                                state_next = ST_SHIFT;
                            end
                        end
                        OP_READ_S:
                        begin
                            sgn_next = 1'b1;
                            top_next = sat_s[TOP_W-1:0];
                            rem_next = sat_s + CNT_W'(1);
                            if (cur_in)
                            begin
                                state_next = ST_SHIFT;
                            end
                        end
                        OP_REWIND:
                        begin
                            cursor_next = '0;
                            rem_next    = '0;
                        end
                        default:
                        begin
                            rem_next = '0;
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                acc_next    = acc_merge;
                cursor_next = cursor_adv;
                rem_next    = rem_left;
                if (rem_left == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (!nxt_in)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // bits past the valid length read as zero
                acc_next   = acc_reg << rem_reg;
                rem_next   = '0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_field_next = (sgn_reg && acc_reg[top_reg]) ? (acc_reg | sign_mask)
                                                                   : acc_reg;
                    out_bytes_next = round_sum[15:3];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        sgn_reg       <= sgn_next;
        top_reg       <= top_next;
        out_field_reg <= out_field_next;
        out_bytes_reg <= out_bytes_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_bytes_reg, out_field_reg};

    `MFBR_ASSERT_NOW(a_shift_in_range, state_reg == ST_SHIFT, cur_in,
        "shifting a byte outside the valid length")
    `MFBR_ASSERT_NOW(a_shift_rem_bound, state_reg == ST_SHIFT,
        (rem_reg != '0) && (rem_reg <= CNT_W'(MAX_FIELD_BITS)),
        "bits left out of range while shifting")
    `MFBR_ASSERT_NEXT(a_rewind_clears, s_accept && (in_op == OP_REWIND), cursor_reg == '0,
        "cursor not cleared by rewind")
    `MFBR_ASSERT_NEXT(a_cursor_forward, state_reg == ST_SHIFT,
        cursor_reg > $past(cursor_reg), "cursor did not advance on a shift step")
    `MFBR_ASSERT_NEXT(a_done_holds, (state_reg == ST_DONE) && out_valid_reg && !m_tready,
        state_reg == ST_DONE, "result dropped while output stalled")

endmodule

`default_nettype wire
